FILE: hdl/brs_pkg.sv
// shared constants, word types and codes of the best route search block
`timescale 1ns / 1ps
`default_nettype none
package brs_pkg;

	localparam int NODES   = 64;
	localparam int NODE_W  = 6;
	localparam int EDGES   = 512;
	localparam int EDGE_AW = 9;
	localparam int ECNT_W  = 10;
	localparam int VAL_W   = 10;
	localparam int HAP_W   = 8;
	localparam int COST_W  = 16;
	localparam int SUM_W   = 14;
	localparam int CNT_W   = 32;
	localparam int AVG_W   = 8;
	localparam int LEN_W   = 7;

	typedef enum logic [1:0] {
		REQ_HAPPY  = 2'd0,
		REQ_EDGE   = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_SPARE  = 2'd3
	} req_t;

	typedef enum logic {
		CFG_START = 1'b0,
		CFG_DEST  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [VAL_W-1:0]  value;
	} in_word_t;

	typedef struct packed {
		logic [NODE_W-1:0] path_node;
		logic              last;
		logic              found;
		logic [CNT_W-1:0]  route_count;
		logic [COST_W-1:0] min_cost;
		logic [SUM_W-1:0]  max_happy;
		logic [AVG_W-1:0]  avg_happy;
	} out_word_t;

	typedef struct packed {
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [VAL_W-1:0]  cost;
	} edge_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [ECNT_W-1:0] idx;
		logic [COST_W-1:0] cost;
		logic [SUM_W-1:0]  happy;
	} frame_t;

endpackage
`default_nettype wire

FILE: hdl/best_route_search.sv
// top level of the best route search block: configuration, input and output words
//
// Load words (set happiness, add edge) give no result. A search word walks
// every simple path from start_node depth first through the single read port
// of the edge memory: each visited node other than dest_node scans the whole
// edge list, descending into each unmarked neighbour and backtracking at the
// end of the list, and each arrival at dest_node away from the start runs a
// 14-step divide for the per-hop average and the ranking, then copies the path
// node by node when it is kept. The kept path is then sent one node per word.
// No word is taken while a search or its output runs; no clearing pass follows
// reset.
`timescale 1ns / 1ps
`default_nettype none
module best_route_search (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire brs_pkg::in_word_t          in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output brs_pkg::out_word_t              out_data,
	input  wire logic                      cfg_we,
	input  wire brs_pkg::cfg_idx_t          cfg_index,
	input  wire logic [brs_pkg::NODE_W-1:0] cfg_data
);
	import brs_pkg::*;

	logic [NODE_W-1:0] start_q;
	logic [NODE_W-1:0] dest_q;
	logic              idle;
	logic              w_valid;
	logic              w_ready;
	out_word_t         w_word;
	logic              out_valid_q;
	out_word_t         out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= NODE_W'(1);
			dest_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START: start_q <= cfg_data;
				CFG_DEST:  dest_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_ready = idle;

	brs_walker u_walker (
		.clk(clk), .arst_n(arst_n),
		.in_take(in_valid && in_ready), .in_word(in_data),
		.start_node(start_q), .dest_node(dest_q), .idle(idle),
		.wout_valid(w_valid), .wout_ready(w_ready), .wout_word(w_word)
	);

	// output register
	assign w_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (w_ready) begin
			out_valid_q <= w_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (w_ready && w_valid) begin
			out_data_q <= w_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

FILE: hdl/brs_ram.sv
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module brs_ram #(
	parameter int DW = 8,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/brs_div.sv
// restoring divider for the average happiness per hop, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module brs_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [brs_pkg::SUM_W-1:0]  dividend,
	input  wire logic [brs_pkg::NODE_W-1:0] divisor,
	output logic                           done,
	output logic      [brs_pkg::AVG_W-1:0]  quotient
);
	import brs_pkg::*;

	localparam int CW = $clog2(SUM_W);

	logic [NODE_W-1:0] rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [NODE_W-1:0] div_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NODE_W:0]   trial;
	logic              fits;

	// one trial subtraction per step
	always_comb begin
		trial = {rem_q, quo_q[SUM_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? NODE_W'(trial - {1'b0, div_q}) : trial[NODE_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[AVG_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/brs_walker.sv
// graph store, depth-first path walker and best path emitter
`timescale 1ns / 1ps
`default_nettype none
module brs_walker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_take,
	input  wire brs_pkg::in_word_t          in_word,
	input  wire logic [brs_pkg::NODE_W-1:0] start_node,
	input  wire logic [brs_pkg::NODE_W-1:0] dest_node,
	output logic                           idle,
	output logic                           wout_valid,
	input  wire logic                      wout_ready,
	output brs_pkg::out_word_t              wout_word
);
	import brs_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_ENTER   = 12'b0000_0000_0010,
		S_SCAN    = 12'b0000_0000_0100,
		S_EDGE    = 12'b0000_0000_1000,
		S_HAP     = 12'b0000_0001_0000,
		S_DIV     = 12'b0000_0010_0000,
		S_EVAL    = 12'b0000_0100_0000,
		S_COPY    = 12'b0000_1000_0000,
		S_POP     = 12'b0001_0000_0000,
		S_RESTORE = 12'b0010_0000_0000,
		S_EMIT_RD = 12'b0100_0000_0000,
		S_EMIT_WR = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// current frame
	logic [NODE_W-1:0] u_q;
	logic [ECNT_W-1:0] idx_q;
	logic [COST_W-1:0] cost_q;
	logic [SUM_W-1:0]  happy_q;
	logic [NODE_W-1:0] depth_q;
	logic [NODE_W-1:0] v_q;
	logic [VAL_W-1:0]  ecost_q;

	// graph and walk bookkeeping
	logic [ECNT_W-1:0] ecnt_q;
	logic [NODES-1:0]  hvalid_q;
	logic              hv_rd_q;
	logic [NODES-1:0]  mark_q;

	// search figures
	logic [COST_W-1:0] least_q;
	logic [CNT_W-1:0]  routes_q;
	logic [SUM_W-1:0]  bhappy_q;
	logic [AVG_W-1:0]  bavg_q;
	logic [LEN_W-1:0]  blen_q;
	logic [AVG_W-1:0]  avg_q;
	logic [LEN_W-1:0]  copy_q;
	logic [NODE_W-1:0] k_q;

	// memory ports
	logic              edge_we, edge_re;
	logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
	edge_t             edge_wdata, edge_rdata;
	logic              hap_we, hap_re;
	logic [NODE_W-1:0] hap_raddr;
	logic [HAP_W-1:0]  hap_rdata;
	logic              stk_we, stk_re;
	logic [NODE_W-1:0] stk_raddr;
	frame_t            stk_wdata, stk_rdata;
	logic              path_we, path_re;
	logic [NODE_W-1:0] path_raddr;
	logic [NODE_W-1:0] path_rdata;
	logic              best_we, best_re;
	logic [NODE_W-1:0] best_waddr;
	logic [NODE_W-1:0] best_rdata;

	logic              div_start, div_done;
	logic [AVG_W-1:0]  div_quo;

	logic              hit_a, hit;
	logic [NODE_W-1:0] nbr;
	logic [HAP_W-1:0]  hap_val;
	logic              is_new, is_tie, keep;

	brs_ram #(.DW($bits(edge_t)), .AW(EDGE_AW)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
	);

	brs_ram #(.DW(HAP_W), .AW(NODE_W)) u_hap_ram (
		.clk(clk), .we(hap_we), .waddr(in_word.node_a), .wdata(in_word.value[HAP_W-1:0]),
		.re(hap_re), .raddr(hap_raddr), .rdata(hap_rdata)
	);

	brs_ram #(.DW($bits(frame_t)), .AW(NODE_W)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(depth_q), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
	);

	brs_ram #(.DW(NODE_W), .AW(NODE_W)) u_path_ram (
		.clk(clk), .we(path_we), .waddr(depth_q), .wdata(u_q),
		.re(path_re), .raddr(path_raddr), .rdata(path_rdata)
	);

	brs_ram #(.DW(NODE_W), .AW(NODE_W)) u_best_ram (
		.clk(clk), .we(best_we), .waddr(best_waddr), .wdata(path_rdata),
		.re(best_re), .raddr(k_q), .rdata(best_rdata)
	);

	brs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(happy_q), .divisor(depth_q),
		.done(div_done), .quotient(div_quo)
	);

	// neighbor across the edge just read
	always_comb begin
		hit_a   = edge_rdata.a == u_q;
		hit     = hit_a || (edge_rdata.b == u_q);
		nbr     = hit_a ? edge_rdata.b : edge_rdata.a;
		hap_val = hv_rd_q ? hap_rdata : '0;
	end

	// route ranking at the destination
	always_comb begin
		is_new = (routes_q == '0) || (cost_q < least_q);
		is_tie = cost_q == least_q;
		keep   = is_new || (is_tie && ((happy_q > bhappy_q) ||
			((happy_q == bhappy_q) && (avg_q > bavg_q))));
	end

	// memory port control
	always_comb begin
		edge_we    = in_take && (in_word.req_type == REQ_EDGE) &&
			(ecnt_q < ECNT_W'(EDGES));
		edge_waddr = ecnt_q[EDGE_AW-1:0];
		edge_wdata = '{a: in_word.node_a, b: in_word.node_b, cost: in_word.value};
		hap_we     = in_take && (in_word.req_type == REQ_HAPPY);
		edge_re    = (state_q == S_SCAN) && (idx_q < ecnt_q);
		edge_raddr = idx_q[EDGE_AW-1:0];
		hap_re     = (state_q == S_EDGE) && hit && !mark_q[nbr];
		hap_raddr  = nbr;
		path_we    = state_q == S_ENTER;
		stk_we     = state_q == S_HAP;
		stk_wdata  = '{node: u_q, idx: idx_q + 1'b1, cost: cost_q, happy: happy_q};
		stk_re     = (state_q == S_POP) && (depth_q != '0);
		stk_raddr  = depth_q - 1'b1;
		path_re    = (state_q == S_COPY) && ({1'b0, depth_q} >= copy_q);
		path_raddr = copy_q[NODE_W-1:0];
		best_we    = (state_q == S_COPY) && (copy_q != '0);
		best_waddr = NODE_W'(copy_q - 1'b1);
		best_re    = state_q == S_EMIT_RD;
		div_start  = (state_q == S_ENTER) && (u_q == dest_node) && (depth_q != '0);
	end

	// result word
	always_comb begin
		idle       = state_q == S_IDLE;
		wout_valid = state_q == S_EMIT_WR;
		if (routes_q == '0) begin
			wout_word      = '0;
			wout_word.last = 1'b1;
		end else begin
			wout_word.path_node   = best_rdata;
			wout_word.last        = ({1'b0, k_q} + 1'b1) == blen_q;
			wout_word.found       = 1'b1;
			wout_word.route_count = routes_q;
			wout_word.min_cost    = least_q;
			wout_word.max_happy   = bhappy_q;
			wout_word.avg_happy   = bavg_q;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ecnt_q   <= '0;
			hvalid_q <= '0;
			mark_q   <= '0;
			routes_q <= '0;
			least_q  <= '1;
			bhappy_q <= '0;
			bavg_q   <= '0;
			blen_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (hap_we) begin
						hvalid_q[in_word.node_a] <= 1'b1;
					end
					if (edge_we) begin
						ecnt_q <= ecnt_q + 1'b1;
					end
					if (in_take && (in_word.req_type == REQ_SEARCH)) begin
						least_q  <= '1;
						routes_q <= '0;
						bhappy_q <= '0;
						bavg_q   <= '0;
						blen_q   <= '0;
						state_q  <= S_ENTER;
					end
				end
				S_ENTER: begin
					mark_q[u_q] <= 1'b1;
					if (u_q != dest_node) begin
						state_q <= S_SCAN;
					end else if (depth_q == '0) begin
						state_q <= S_EVAL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_SCAN: begin
					state_q <= edge_re ? S_EDGE : S_POP;
				end
				S_EDGE: begin
					state_q <= hap_re ? S_HAP : S_SCAN;
				end
				S_HAP: begin
					state_q <= S_ENTER;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (is_new) begin
						least_q  <= cost_q;
						routes_q <= CNT_W'(1);
					end else if (is_tie && (routes_q != '1)) begin
						routes_q <= routes_q + 1'b1;
					end
					if (keep) begin
						bhappy_q <= happy_q;
						bavg_q   <= avg_q;
						blen_q   <= {1'b0, depth_q} + 1'b1;
						state_q  <= S_COPY;
					end else begin
						state_q <= S_POP;
					end
				end
				S_COPY: begin
					if (copy_q == ({1'b0, depth_q} + 1'b1)) begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					mark_q[u_q] <= 1'b0;
					if (depth_q == '0) begin
						state_q <= (routes_q == '0) ? S_EMIT_WR : S_EMIT_RD;
					end else begin
						state_q <= S_RESTORE;
					end
				end
				S_RESTORE: begin
					state_q <= S_SCAN;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (wout_ready) begin
						state_q <= wout_word.last ? S_IDLE : S_EMIT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// frame and counter datapath
	always_ff @(posedge clk) begin
		hv_rd_q <= hap_re ? hvalid_q[nbr] : hv_rd_q;
		case (state_q)
			S_IDLE: begin
				u_q     <= start_node;
				cost_q  <= '0;
				happy_q <= '0;
				depth_q <= '0;
				k_q     <= '0;
			end
			S_ENTER: begin
				idx_q  <= '0;
				avg_q  <= '0;
				copy_q <= '0;
			end
			S_EDGE: begin
				v_q     <= nbr;
				ecost_q <= edge_rdata.cost;
				if (!hap_re) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_HAP: begin
				u_q     <= v_q;
				cost_q  <= cost_q + COST_W'(ecost_q);
				happy_q <= happy_q + SUM_W'(hap_val);
				depth_q <= depth_q + 1'b1;
			end
			S_DIV: begin
				if (div_done) begin
					avg_q <= div_quo;
				end
			end
			S_COPY: begin
				copy_q <= copy_q + 1'b1;
			end
			S_RESTORE: begin
				u_q     <= stk_rdata.node;
				idx_q   <= stk_rdata.idx;
				cost_q  <= stk_rdata.cost;
				happy_q <= stk_rdata.happy;
				depth_q <= depth_q - 1'b1;
			end
			S_EMIT_WR: begin
				if (wout_ready) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/brs_checker.sv
// port level checks of the best route search block and their bind
`timescale 1ns / 1ps
`default_nettype none
module brs_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_ready,
	input  wire brs_pkg::in_word_t          in_data,
	input  wire logic                      out_valid,
	input  wire logic                      out_ready,
	input  wire brs_pkg::out_word_t         out_data
);
	import brs_pkg::*;

	// a search word blocks further input
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.req_type == REQ_SEARCH) |=> !in_ready)
		else $error("input taken right after a search word");

	// a load word leaves the block ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.req_type != REQ_SEARCH) |=> in_ready)
		else $error("load word stalled the input");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output word changed while stalled");

	// empty result is a single last word, found path counts at least one route
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.found ? (out_data.route_count != '0) :
			(out_data.last && out_data.route_count == '0)))
		else $error("inconsistent found and route count");

endmodule

bind best_route_search brs_checker u_brs_checker (.*);
`default_nettype wire

FILE: bench/best_route_search_test.sv
// self-checking bench for the best route search block: directed table, then random loads and searches
`timescale 1ns / 1ps
module best_route_search_test;
	import brs_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;
	localparam int DRAIN = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_START;
	logic [NODE_W-1:0] cfg_data = '0;

	best_route_search i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the graph and search figures
	logic [NODE_W-1:0] sh_start = 6'd1;
	logic [NODE_W-1:0] sh_dest = 6'd0;
	logic [HAP_W-1:0] sh_happy [NODES];
	logic [NODE_W-1:0] sh_ea [EDGES];
	logic [NODE_W-1:0] sh_eb [EDGES];
	logic [VAL_W-1:0] sh_ec [EDGES];
	int sh_ecount = 0;
	bit sh_mark [NODES];
	logic [NODE_W-1:0] sh_walk [NODES];
	logic [NODE_W-1:0] sh_best [NODES];
	int sh_blen, sh_lcost, sh_routes, sh_bhappy, sh_bavg;

	out_word_t route_words [$];
	int errors = 0;
	int items_sent = 0;
	int words_seen = 0;
	int searches = 0;
	int cycles = 0;
	int idle_in_pct = 0;
	int idle_out_pct = 0;

	// keep the walked path as the best one
	function automatic void keep_walk(int len, int hp, int av);
		for (int k = 0; k < len; k++)
			sh_best[k] = sh_walk[k];
		sh_blen = len;
		sh_bhappy = hp;
		sh_bavg = av;
	endfunction

	// depth-first walk over simple paths
	function automatic void route_walk(int u, int cost, int hp, int hops);
		int v;
		int av;
		if (hops >= NODES || sh_mark[u])
			return;
		sh_mark[u] = 1'b1;
		sh_walk[hops] = u[NODE_W-1:0];
		if (u == sh_dest) begin
			av = hops ? hp / hops : 0;
			if (sh_routes == 0 || cost < sh_lcost) begin
				sh_lcost = cost;
				sh_routes = 1;
				keep_walk(hops + 1, hp, av);
			end else if (cost == sh_lcost) begin
				if (sh_routes != 32'hFFFF_FFFF)
					sh_routes++;
				if (hp > sh_bhappy || (hp == sh_bhappy && av > sh_bavg))
					keep_walk(hops + 1, hp, av);
			end
		end else begin
			for (int i = 0; i < sh_ecount; i++) begin
				if (sh_ea[i] == u)
					v = sh_eb[i];
				else if (sh_eb[i] == u)
					v = sh_ea[i];
				else
					continue;
				route_walk(v, cost + sh_ec[i], hp + sh_happy[v], hops + 1);
			end
		end
		sh_mark[u] = 1'b0;
	endfunction

	// apply one accepted word to the shadow state, queue the route words it causes
	function automatic void predict_route(in_word_t w, bit use_typed, out_word_t typed);
		out_word_t r;
		case (w.req_type)
			REQ_HAPPY: sh_happy[w.node_a] = w.value[HAP_W-1:0];
			REQ_EDGE: begin
				if (sh_ecount < EDGES) begin
					sh_ea[sh_ecount] = w.node_a;
					sh_eb[sh_ecount] = w.node_b;
					sh_ec[sh_ecount] = w.value;
					sh_ecount++;
				end
			end
			REQ_SEARCH: begin
				searches++;
				sh_lcost = 16'hFFFF;
				sh_routes = 0;
				sh_bhappy = 0;
				sh_bavg = 0;
				sh_blen = 0;
				for (int k = 0; k < NODES; k++)
					sh_mark[k] = 1'b0;
				route_walk(sh_start, 0, 0, 0);
				if (use_typed) begin
					route_words = {route_words, typed};
				end else if (sh_routes == 0 || sh_blen == 0) begin
					r = '0;
					r.last = 1'b1;
					route_words = {route_words, r};
				end else begin
					for (int k = 0; k < sh_blen; k++) begin
						r.path_node = sh_best[k];
						r.last = (k + 1 == sh_blen);
						r.found = 1'b1;
						r.route_count = sh_routes;
						r.min_cost = sh_lcost[COST_W-1:0];
						r.max_happy = sh_bhappy[SUM_W-1:0];
						r.avg_happy = sh_bavg[AVG_W-1:0];
						route_words = {route_words, r};
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic in_word_t mk(logic [1:0] rq, int a, int b, int v);
		in_word_t w;
		w.req_type = rq;
		w.node_a = a[NODE_W-1:0];
		w.node_b = b[NODE_W-1:0];
		w.value = v[VAL_W-1:0];
		return w;
	endfunction

	function automatic out_word_t route_word(int pn, bit fd, int cnt, int cst, int hp, int av);
		out_word_t r;
		r.path_node = pn[NODE_W-1:0];
		r.last = 1'b1;
		r.found = fd;
		r.route_count = cnt;
		r.min_cost = cst[COST_W-1:0];
		r.max_happy = hp[SUM_W-1:0];
		r.avg_happy = av[AVG_W-1:0];
		return r;
	endfunction

	// send one word, with optional idle gap first
	task automatic send_word(in_word_t w, bit use_typed, out_word_t typed);
		if ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		predict_route(w, use_typed, typed);
		items_sent++;
	endtask

	task automatic release_input;
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained;
		while (route_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_reg(cfg_idx_t idx, int d);
		release_input();
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d[NODE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START)
			sh_start = d[NODE_W-1:0];
		else
			sh_dest = d[NODE_W-1:0];
	endtask

	// directed table
	typedef struct {
		bit is_cfg;
		cfg_idx_t ci;
		int cd;
		in_word_t w;
		bit typed;
		out_word_t x;
	} row_t;
	row_t rows [$];

	function automatic row_t blank_row();
		row_t r;
		r.is_cfg = 1'b0;
		r.ci = CFG_START;
		r.cd = 0;
		r.w = '0;
		r.typed = 1'b0;
		r.x = '0;
		return r;
	endfunction

	function automatic void row_item(in_word_t w);
		row_t r;
		r = blank_row();
		r.w = w;
		rows = {rows, r};
	endfunction

	function automatic void row_typed(in_word_t w, out_word_t x);
		row_t r;
		r = blank_row();
		r.w = w;
		r.typed = 1'b1;
		r.x = x;
		rows = {rows, r};
	endfunction

	function automatic void row_cfg(cfg_idx_t ci, int d);
		row_t r;
		r = blank_row();
		r.is_cfg = 1'b1;
		r.ci = ci;
		r.cd = d;
		rows = {rows, r};
	endfunction

	// receive side: stall pattern and check of each route word
	always @(posedge clk) begin
		out_word_t x;
		cycles <= cycles + 1;
		out_ready <= ($urandom_range(99) >= idle_out_pct);
		if (arst_n && out_valid && out_ready) begin
			words_seen <= words_seen + 1;
			if (route_words.size() == 0) begin
				$error("route word with nothing expected: %h", out_data);
				errors = errors + 1;
			end else begin
				x = route_words.pop_front();
				if (out_data.path_node !== x.path_node) begin
					$error("path_node exp %0d got %0d", x.path_node, out_data.path_node);
					errors = errors + 1;
				end
				if (out_data.last !== x.last) begin
					$error("last exp %0d got %0d", x.last, out_data.last);
					errors = errors + 1;
				end
				if (out_data.found !== x.found) begin
					$error("found exp %0d got %0d", x.found, out_data.found);
					errors = errors + 1;
				end
				if (out_data.route_count !== x.route_count) begin
					$error("route_count exp %0d got %0d", x.route_count, out_data.route_count);
					errors = errors + 1;
				end
				if (out_data.min_cost !== x.min_cost) begin
					$error("min_cost exp %0d got %0d", x.min_cost, out_data.min_cost);
					errors = errors + 1;
				end
				if (out_data.max_happy !== x.max_happy) begin
					$error("max_happy exp %0d got %0d", x.max_happy, out_data.max_happy);
					errors = errors + 1;
				end
				if (out_data.avg_happy !== x.avg_happy) begin
					$error("avg_happy exp %0d got %0d", x.avg_happy, out_data.avg_happy);
					errors = errors + 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		out_word_t none_w;
		int pool [10] = '{0, 1, 2, 3, 4, 5, 60, 61, 62, 63};
		int edge_budget;
		int pick;
		none_w = route_word(0, 1'b0, 0, 0, 0, 0);
		for (int k = 0; k < NODES; k++) begin
			sh_happy[k] = '0;
			sh_mark[k] = 1'b0;
		end

		// directed rows
		row_typed(mk(REQ_SEARCH, 0, 0, 0), none_w);
		row_item(mk(REQ_SPARE, 63, 63, 1023));
		row_item(mk(REQ_HAPPY, 63, 0, 1023));
		row_item(mk(REQ_HAPPY, 0, 63, 1023));
		row_item(mk(REQ_HAPPY, 2, 0, 100));
		row_item(mk(REQ_HAPPY, 3, 0, 200));
		row_item(mk(REQ_EDGE, 1, 2, 5));
		row_item(mk(REQ_EDGE, 2, 0, 5));
		row_item(mk(REQ_EDGE, 1, 0, 10));
		row_item(mk(REQ_EDGE, 1, 3, 0));
		row_item(mk(REQ_EDGE, 3, 0, 10));
		row_item(mk(REQ_EDGE, 2, 2, 1));
		row_item(mk(REQ_EDGE, 63, 62, 1023));
		row_item(mk(REQ_SEARCH, 63, 0, 0));
		row_cfg(CFG_DEST, 1);
		row_typed(mk(REQ_SEARCH, 0, 0, 0), route_word(1, 1'b1, 1, 0, 0, 0));
		row_cfg(CFG_START, 63);
		row_cfg(CFG_DEST, 0);
		row_typed(mk(REQ_SEARCH, 0, 0, 0), none_w);
		row_cfg(CFG_START, 0);
		row_cfg(CFG_DEST, 63);
		row_typed(mk(REQ_SEARCH, 0, 0, 0), none_w);
		row_cfg(CFG_START, 62);
		row_item(mk(REQ_SEARCH, 0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_in_pct = 25;
		idle_out_pct = 60;
		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_reg(rows[i].ci, rows[i].cd);
			else
				send_word(rows[i].w, rows[i].typed, rows[i].x);
		end

		// random part in three idle modes; graph kept small to bound the walk
		edge_budget = 8;
		for (int ph = 0; ph < 3; ph++) begin
			idle_in_pct = (ph == 0) ? 25 : (ph == 1) ? 60 : 0;
			idle_out_pct = (ph == 0) ? 60 : (ph == 1) ? 25 : 0;
			write_reg(CFG_START, (ph == 1) ? 0 : pool[$urandom_range(9)]);
			write_reg(CFG_DEST, (ph == 1) ? 63 : pool[$urandom_range(9)]);
			for (int n = 0; n < 46; n++) begin
				if (n == 27) begin
					write_reg(CFG_START, pool[$urandom_range(5)]);
					write_reg(CFG_DEST, pool[$urandom_range(5)]);
				end
				if (ph == 0 && n == 15) begin
					// hold the sender until every route word is out
					release_input();
					while (route_words.size() != 0)
						@(posedge clk);
				end
				pick = $urandom_range(99);
				if (pick < 40)
					send_word(mk(REQ_SEARCH, $urandom_range(63), $urandom_range(63),
						$urandom_range(1023)), 1'b0, none_w);
				else if (pick < 55 && edge_budget > 0) begin
					edge_budget--;
					send_word(mk(REQ_EDGE, pool[$urandom_range(9)], pool[$urandom_range(9)],
						$urandom_range(1023)), 1'b0, none_w);
				end else if (pick < 90)
					send_word(mk(REQ_HAPPY, $urandom_range(63), $urandom_range(63),
						$urandom_range(1023)), 1'b0, none_w);
				else
					send_word(mk(REQ_SPARE, $urandom_range(63), $urandom_range(63),
						$urandom_range(1023)), 1'b0, none_w);
			end
		end

		// lone nodes: no route between them, then start equal to destination
		write_reg(CFG_START, 50);
		write_reg(CFG_DEST, 51);
		send_word(mk(REQ_SEARCH, 0, 0, 0), 1'b1, none_w);
		write_reg(CFG_DEST, 50);
		send_word(mk(REQ_SEARCH, 0, 0, 0), 1'b1, route_word(50, 1'b1, 1, 0, 0, 0));

		release_input();
		wait_drained();
		$display("covered %0d input words, %0d searches, %0d route words checked",
			items_sent, searches, words_seen);
		$display("directed extremes, three stall modes, an idle pause and a one-node route");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/brs_pkg.sv
hdl/brs_ram.sv
hdl/brs_div.sv
hdl/brs_walker.sv
hdl/best_route_search.sv
hdl/brs_checker.sv
bench/best_route_search_test.sv
